[rtl/core/rle8_pkg.sv]
// Shared types and constants for the RLE8 run encoder.
package rle8_pkg;

    localparam int LW_W   = 16;
    localparam int BYTE_W = 8;
    localparam int QDEPTH = 4;

    // Slot positions inside a command, in emission order
    localparam int SLOT_R0  = 0;
    localparam int SLOT_EOL = 1;
    localparam int SLOT_R1  = 2;
    localparam int SLOT_EOB = 3;
    localparam int NSLOT    = 4;

    localparam logic [BYTE_W-1:0] ESC_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] EOL_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] EOB_CODE = 8'h01;

    typedef logic [NSLOT-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t        mask;
        logic [BYTE_W-1:0] r0_cnt;
        logic [BYTE_W-1:0] r0_val;
        logic [BYTE_W-1:0] r1_cnt;
        logic [BYTE_W-1:0] r1_val;
    } cmd_t;

endpackage

[rtl/core/rle8_front.sv]
// Front end: run tracking, line counting and command generation per pixel.
module rle8_front #(
    parameter int MAX_RUN = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rle8_pkg::LW_W-1:0]  cfg_wdata,
    input  logic                       accept,
    input  logic [rle8_pkg::BYTE_W-1:0] pixel,
    input  logic                       last_pixel,
    output rle8_pkg::cmd_t             cmd,
    output logic                       has_pairs
);
    import rle8_pkg::*;

    localparam logic [BYTE_W-1:0] MaxRun = BYTE_W'(MAX_RUN);

    logic [LW_W-1:0]   line_width_reg;
    logic [BYTE_W-1:0] run_length_reg;
    logic [BYTE_W-1:0] run_value_reg;
    logic [LW_W-1:0]   column_reg;
    logic              image_start_reg;

    logic [LW_W-1:0]   lw_eff;
    logic              eol;
    logic [BYTE_W-1:0] len_a;
    logic              brk;
    logic              restart;
    logic [BYTE_W-1:0] run_length_next;
    logic [BYTE_W-1:0] run_value_next;
    logic [LW_W-1:0]   column_next;

    always_comb
    begin
        lw_eff  = (line_width_reg == '0) ? LW_W'(1) : line_width_reg;
        eol     = !image_start_reg && (column_reg >= lw_eff);
        len_a   = eol ? '0 : run_length_reg;
        // full run or value change closes the open run
        brk     = (len_a >= MaxRun) || ((len_a != '0) && (pixel != run_value_reg));
        restart = (len_a == '0) || brk;

        run_length_next = restart ? BYTE_W'(1) : len_a + BYTE_W'(1);
        run_value_next  = restart ? pixel : run_value_reg;
        column_next     = (eol ? '0 : column_reg) + LW_W'(1);

        cmd.mask           = '0;
        cmd.mask[SLOT_R0]  = eol ? (run_length_reg != '0) : brk;
        cmd.mask[SLOT_EOL] = eol;
        cmd.mask[SLOT_R1]  = last_pixel;
        cmd.mask[SLOT_EOB] = last_pixel;
        cmd.r0_cnt         = run_length_reg;
        cmd.r0_val         = run_value_reg;
        cmd.r1_cnt         = run_length_next;
        cmd.r1_val         = run_value_next;
        has_pairs          = (cmd.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LW_W'(1);
            run_length_reg  <= '0;
            run_value_reg   <= '0;
            column_reg      <= '0;
            image_start_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                line_width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (last_pixel)
                begin
                    run_length_reg  <= '0;
                    run_value_reg   <= '0;
                    column_reg      <= '0;
                    image_start_reg <= 1'b1;
                end
                else
                begin
                    run_length_reg  <= run_length_next;
                    run_value_reg   <= run_value_next;
                    column_reg      <= column_next;
                    image_start_reg <= 1'b0;
                end
            end
        end
    end

endmodule

[rtl/core/rle8_queue.sv]
// Small command FIFO between front and back ends.
module rle8_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rle8_pkg::cmd_t push_cmd,
    input  logic           pop,
    output rle8_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import rle8_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(QDEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % QDEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % QDEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

[rtl/core/rle8_back.sv]
// Back end: walks the slots of the head command, one pair per cycle while the output is not stalled.
module rle8_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rle8_pkg::cmd_t              head,
    input  logic                        q_empty,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [rle8_pkg::BYTE_W-1:0] count_byte,
    output logic [rle8_pkg::BYTE_W-1:0] value_byte,
    output logic                        last_of_item
);
    import rle8_pkg::*;

    slot_mask_t        done_reg;
    slot_mask_t        done_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] count_reg;
    logic [BYTE_W-1:0] value_reg;
    logic              last_reg;

    logic              advance;
    logic              take;
    slot_mask_t        pending;
    slot_mask_t        sel;
    slot_mask_t        remaining;
    logic [BYTE_W-1:0] count_next;
    logic [BYTE_W-1:0] value_next;

    always_comb
    begin
        advance   = !out_valid_reg || !out_stall;
        take      = advance && !q_empty;
        pending   = head.mask & ~done_reg;
        sel       = pending & (~pending + slot_mask_t'(1));
        remaining = pending & ~sel;
        pop       = take && (remaining == '0);
        done_next = pop ? '0 : (take ? (done_reg | sel) : done_reg);

        priority if (pending[SLOT_R0])
        begin
            count_next = head.r0_cnt;
            value_next = head.r0_val;
        end
        else if (pending[SLOT_EOL])
        begin
            count_next = ESC_CODE;
            value_next = EOL_CODE;
        end
        else if (pending[SLOT_R1])
        begin
            count_next = head.r1_cnt;
            value_next = head.r1_val;
        end
        else
        begin
            count_next = ESC_CODE;
            value_next = EOB_CODE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (advance)
            begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            count_reg <= count_next;
            value_reg <= value_next;
            last_reg  <= (remaining == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign count_byte   = count_reg;
    assign value_byte   = value_reg;
    assign last_of_item = last_reg;

    a_eob_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && count_reg == ESC_CODE && value_reg == EOB_CODE) |-> last_reg)
        else $error("end-of-bitmap pair not marked last");

    a_stalled_pair_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(count_reg)
            && $stable(value_reg) && $stable(last_reg)))
        else $error("stalled pair changed");

endmodule

[rtl/core/bmp_rle8_run_encoder_top.sv]
// Top level of the BMP RLE8 encoded-mode run encoder.
// Takes one 8-bit palette pixel per item and emits (count, value) pairs:
// runs of equal pixels up to MAX_RUN long, an end-of-line pair (0,0) when
// the first pixel of a new line arrives after line_width pixels, and after
// the pixel flagged last_pixel the open run plus end-of-bitmap (0,1), then
// the run and column state return to reset. The front end classifies each
// pixel combinationally and pushes a command holding all the pairs it
// causes into a 4-entry queue; while the output does not stall, the back
// end emits one pair per cycle from the queue head through an output
// register. Each item yields 0 to 4 pairs, so a pixel stream with at most
// one pair per pixel runs at one item per cycle while the output does not
// stall; in_stall rises only when the queue is full because the output
// side is slower. line_width (0 acts as 1) is written through
// cfg_we/cfg_wdata and should change only while the encoder is idle.
module bmp_rle8_run_encoder_top #(
    parameter int MAX_RUN = 255
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // line width register
    input  logic                        cfg_we,
    input  logic [rle8_pkg::LW_W-1:0]   cfg_wdata,
    // pixel input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rle8_pkg::BYTE_W-1:0] pixel,
    input  logic                        last_pixel,
    // pair output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rle8_pkg::BYTE_W-1:0] count_byte,
    output logic [rle8_pkg::BYTE_W-1:0] value_byte,
    output logic                        last_of_item
);
    import rle8_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic has_pairs;
    logic accept;
    logic q_full;
    logic q_empty;
    logic pop;

    // queue full is the only back-pressure on pixels
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    rle8_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .cmd        (front_cmd),
        .has_pairs  (has_pairs)
    );

    // pixels that only extend a run push nothing
    rle8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept && has_pairs),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    rle8_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .count_byte   (count_byte),
        .value_byte   (value_byte),
        .last_of_item (last_of_item)
    );

endmodule
